// ----- rtl/core/param_sync_packet_checker_assert.svh -----
// Assertion macros for the parameter sync packet checker
`ifndef PARAM_SYNC_PACKET_CHECKER_ASSERT_SVH
`define PARAM_SYNC_PACKET_CHECKER_ASSERT_SVH
// clocked implication with reset disable
`define PSPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// clocked next-cycle implication with reset disable
`define PSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/pspc_pkg.sv -----
// Shared types and constants for the parameter sync packet checker
package pspc_pkg;
  localparam logic [7:0] PKT_BYTES     = 8'd9;
  localparam logic [7:0] PKT_LEN_FIELD = 8'd8;
  localparam logic [7:0] PKT_HEADER    = 8'h3C;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_BLEN = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_SUM  = 3'd3,
    ST_BAD_HDR  = 3'd4,
    ST_BAD_ID   = 3'd5
  } status_e;

  // Result of one packet check, handed to the state update
  typedef struct packed {
    status_e     status;
    logic [31:0] stored;
    logic [4:0]  id;
  } check_t;

  // Truncate an IEEE single to an unsigned byte, saturating
  function automatic logic [7:0] float_to_byte(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [23:0] sig;
    logic [2:0]  sh;
    expo = bits[30:23];
    frac = bits[22:0];
    sig  = {1'b1, frac};
    sh   = expo[2:0] + 3'd1;
    if (expo == 8'hFF && frac != '0)   float_to_byte = 8'd0;
    else if (bits[31])                 float_to_byte = 8'd0;
    else if (expo < 8'd127)            float_to_byte = 8'd0;
    else if (expo >= 8'd135)           float_to_byte = 8'd255;
    else                               float_to_byte = 8'(sig[23:16] >> (3'd7 - sh));
  endfunction
endpackage

// ----- rtl/core/pspc_check.sv -----
// Packet checks and stored word selection, purely combinational
module pspc_check #(
  parameter int unsigned ENTRY_COUNT = 23
) (
  input  logic [7:0]          blen_i,
  input  logic [7:0]          len_i,
  input  logic [7:0]          hdr_i,
  input  logic [7:0]          id_i,
  input  logic [31:0]         val_i,
  input  logic [15:0]         chk_i,
  output pspc_pkg::check_t    res_o
);
  import pspc_pkg::*;

  logic [15:0] sum;
  logic        conv;

  // sum seven bytes
  assign sum = 16'(len_i) + 16'(hdr_i) + 16'(id_i) + 16'(val_i[7:0]) + 16'(val_i[15:8])
             + 16'(val_i[23:16]) + 16'(val_i[31:24]);
  assign conv = (id_i == 8'd0) || (id_i == 8'd12) || (id_i == 8'd21) || (id_i == 8'd22);

  // rank checks in order
  always_comb begin
    priority if (blen_i != PKT_BYTES)          res_o.status = ST_BAD_BLEN;
    else if (len_i != PKT_LEN_FIELD)           res_o.status = ST_BAD_LEN;
    else if (chk_i != sum)                     res_o.status = ST_BAD_SUM;
    else if (hdr_i != PKT_HEADER)              res_o.status = ST_BAD_HDR;
    else if (9'(id_i) >= 9'(ENTRY_COUNT))      res_o.status = ST_BAD_ID;
    else                                       res_o.status = ST_OK;
    if (res_o.status != ST_OK)  res_o.stored = '0;
    else if (conv)              res_o.stored = {24'd0, float_to_byte(val_i)};
    else                        res_o.stored = val_i;
    res_o.id = id_i[4:0];
  end
endmodule

// ----- rtl/core/param_sync_packet_checker.sv -----
// Top level of the parameter sync packet checker
// Takes one 9-byte parameter packet per beat and returns one result beat per packet,
// in the cycle after acceptance. Throughput is one packet per cycle unless a held
// result is stalled: the checks, the seven-byte checksum and the counter updates sit
// between the input handshake and the result register. The stored value word is
// reported on the result; the mask and counters show the state after the packet.
module param_sync_packet_checker #(
  parameter int unsigned ENTRY_COUNT    = 23,
  parameter int unsigned CONFIG_ENTRIES = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  buffer_length_i,
  input  logic [7:0]  length_byte_i,
  input  logic [7:0]  header_byte_i,
  input  logic [7:0]  entry_id_i,
  input  logic [31:0] value_bits_i,
  input  logic [15:0] check_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] stored_word_o,
  output logic [31:0] packets_seen_o,
  output logic [31:0] packets_good_o,
  output logic [31:0] packets_bad_o,
  output logic [31:0] arrived_mask_o,
  output logic        sync_complete_o
);
  import pspc_pkg::*;

  localparam logic [31:0] WantMask = 32'((64'd1 << CONFIG_ENTRIES) - 64'd1);

  check_t      chk;
  logic        acc;
  logic        valid_q;
  logic [31:0] seen_q, good_q, bad_q, mask_q;
  logic [31:0] mask_d;
  logic [2:0]  status_q;
  logic [31:0] stored_q;

  pspc_check #(.ENTRY_COUNT(ENTRY_COUNT)) u_check (
    .blen_i(buffer_length_i), .len_i(length_byte_i), .hdr_i(header_byte_i),
    .id_i(entry_id_i), .val_i(value_bits_i), .chk_i(check_word_i), .res_o(chk)
  );

  // accept whenever the result register is free or drains this cycle
  assign in_stall_o = valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign mask_d     = (chk.status == ST_OK) ? (mask_q | (32'd1 << chk.id)) : mask_q;

  // advance state and result on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seen_q  <= '0;
      good_q  <= '0;
      bad_q   <= '0;
      mask_q  <= '0;
    end else begin
      if (acc) begin
        valid_q <= 1'b1;
        seen_q  <= seen_q + 32'd1;
        mask_q  <= mask_d;
        if (chk.status == ST_OK) good_q <= good_q + 32'd1;
        else                     bad_q  <= bad_q + 32'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // hold payload of the result beat
  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= chk.status;
      stored_q <= chk.stored;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = status_q;
  assign stored_word_o   = stored_q;
  assign packets_seen_o  = seen_q;
  assign packets_good_o  = good_q;
  assign packets_bad_o   = bad_q;
  assign arrived_mask_o  = mask_q;
  assign sync_complete_o = ((mask_q & WantMask) == WantMask);
endmodule

// ----- rtl/core/pspc_checker.sv -----
// Port-level assertions for the parameter sync packet checker, with bind
`include "param_sync_packet_checker_assert.svh"
module pspc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] packets_seen_o,
  input logic [31:0] packets_good_o,
  input logic [31:0] packets_bad_o
);
  `PSPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
  `PSPC_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_o)
  `PSPC_ASSERT_NEXT(a_accept_shows, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
  `PSPC_ASSERT_IMP(a_counts_sum, clk_i, rst_ni, 1'b1, packets_seen_o == packets_good_o + packets_bad_o)
  `PSPC_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= 3'd5)
endmodule

bind param_sync_packet_checker pspc_checker u_pspc_checker (.*);
